/* hdl/bsd_pkg.sv */
package bsd_pkg;

   localparam int RUN_W      = 14;
   localparam int MUL_W      = RUN_W + 3;
   localparam int TOTAL_W    = 32;
   localparam int DIGIT_W    = 4;
   localparam int CODE_DIGITS = 8;
   localparam int POS_W      = $clog2(CODE_DIGITS);
   localparam int FIFO_DEPTH = 4;

   localparam logic [DIGIT_W-1:0] DIGIT_BAD = 4'hF;

   // One queued word: what a single input bit asks of the back end, in order:
   // frame start, pattern decode, row end, frame result.
   typedef struct packed {
      logic             frame_start;
      logic             pattern;
      logic             row_end;
      logic             frame_end;
      logic [RUN_W-1:0] run_last;
      logic [RUN_W-1:0] run_zero;
      logic [RUN_W-1:0] run_first;
   } event_type;

endpackage

/* hdl/bsd_if.sv */
interface bsd_req_if;
   logic valid;
   logic ready;
   logic bit_now;
   logic bit_above;
   logic row_end;
   logic frame_start;
   logic frame_end;

   modport source(output valid, bit_now, bit_above, row_end, frame_start, frame_end,
                  input ready);
   modport sink(input valid, bit_now, bit_above, row_end, frame_start, frame_end,
                output ready);
endinterface

interface bsd_rsp_if;
   import bsd_pkg::*;
   logic               valid;
   logic               ready;
   logic [TOTAL_W-1:0] digit_total;
   logic               frame_done;

   modport source(output valid, digit_total, frame_done, input ready);
   modport sink(input valid, digit_total, frame_done, output ready);
endinterface

/* hdl/bsd_front.sv */
module bsd_front (
   input  logic                clock,
   input  logic                reset,
   bsd_req_if.sink             req_chan,
   input  logic                fifo_full,
   output logic                push,
   output bsd_pkg::event_type  push_word
);
   import bsd_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_ONES_A = 4'b0010,
      PH_ZEROS  = 4'b0100,
      PH_ONES_B = 4'b1000
   } phase_type;

   phase_type        phase_ff, phase_in, phase_cur;
   logic [RUN_W-1:0] run_last_ff, run_zero_ff, run_first_ff;
   logic [RUN_W-1:0] run_last_in, run_zero_in, run_first_in;
   logic [RUN_W-1:0] last_cur, zero_cur, first_cur;
   logic             accept, pat_done;

   function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] v);
      return (v == '1) ? v : v + RUN_W'(1);
   endfunction

   assign req_chan.ready = !fifo_full;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      // frame start clears the row before this bit
      phase_cur = req_chan.frame_start ? PH_IDLE : phase_ff;
      last_cur  = req_chan.frame_start ? '0 : run_last_ff;
      zero_cur  = req_chan.frame_start ? '0 : run_zero_ff;
      first_cur = req_chan.frame_start ? '0 : run_first_ff;
      phase_in     = phase_cur;
      run_last_in  = last_cur;
      run_zero_in  = zero_cur;
      run_first_in = first_cur;
      pat_done     = 1'b0;
      unique case (phase_cur)
         PH_IDLE: begin
            if (req_chan.bit_now && !req_chan.bit_above) begin
               run_last_in  = '0;
               run_zero_in  = '0;
               run_first_in = RUN_W'(1);
               phase_in     = PH_ONES_A;
            end
         end
         PH_ONES_A: begin
            if (req_chan.bit_now) begin
               run_first_in = run_inc(first_cur);
            end else begin
               run_zero_in = RUN_W'(1);
               phase_in    = PH_ZEROS;
            end
         end
         PH_ZEROS: begin
            if (!req_chan.bit_now) begin
               run_zero_in = run_inc(zero_cur);
            end else begin
               run_last_in = RUN_W'(1);
               phase_in    = PH_ONES_B;
            end
         end
         PH_ONES_B: begin
            if (req_chan.bit_now) begin
               run_last_in = run_inc(last_cur);
            end else begin
               pat_done = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
      if (req_chan.row_end) begin
         phase_in     = PH_IDLE;
         run_last_in  = '0;
         run_zero_in  = '0;
         run_first_in = '0;
      end
   end

   assign push_word.frame_start = req_chan.frame_start;
   assign push_word.pattern     = pat_done;
   assign push_word.row_end     = req_chan.row_end;
   assign push_word.frame_end   = req_chan.frame_end;
   assign push_word.run_last    = last_cur;
   assign push_word.run_zero    = zero_cur;
   assign push_word.run_first   = first_cur;

   assign push = accept && (pat_done || req_chan.frame_start || req_chan.row_end ||
                            req_chan.frame_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         run_last_ff  <= '0;
         run_zero_ff  <= '0;
         run_first_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         run_last_ff  <= run_last_in;
         run_zero_ff  <= run_zero_in;
         run_first_ff <= run_first_in;
      end
   end

endmodule

/* hdl/bsd_fifo.sv */
module bsd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bsd_pkg::event_type  push_word,
   input  logic                pop,
   output bsd_pkg::event_type  pop_word,
   output logic                full,
   output logic                empty
);
   import bsd_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   event_type        slot_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

/* hdl/bsd_back.sv */
module bsd_back (
   input  logic                clock,
   input  logic                reset,
   input  bsd_pkg::event_type  pop_word,
   input  logic                fifo_empty,
   output logic                pop,
   bsd_rsp_if.source           rsp_chan
);
   import bsd_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MIN   = 9'b000000010,
      ST_MULT  = 9'b000000100,
      ST_QUOT  = 9'b000001000,
      ST_STORE = 9'b000010000,
      ST_CHECK = 9'b000100000,
      ST_TOTAL = 9'b001000000,
      ST_TAIL  = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   event_type          word_ff, word_in;
   logic [RUN_W-1:0]   mn_ff, mn_in;
   logic [MUL_W-1:0]   m2_ff, m3_ff, m4_ff, m5_ff;
   logic [MUL_W-1:0]   m2_in, m3_in, m4_in, m5_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [DIGIT_W-1:0] store_ff [CODE_DIGITS];
   logic [DIGIT_W-1:0] store_in [CODE_DIGITS];
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               skip_ff, skip_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [6:0]         sum_ff, sum_in;
   logic               sum_ok_ff, sum_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic [2:0]         q_last, q_zero, q_first;
   logic               over;
   logic [5:0]         even, odd;
   logic [7:0]         chk;
   logic [TOTAL_W:0]   total_sum;

   // quotient of r by mn, counted by compares against the multiples of mn
   function automatic logic [2:0] quot(input logic [RUN_W-1:0] r,
                                       input logic [RUN_W-1:0] m1,
                                       input logic [MUL_W-1:0] m2,
                                       input logic [MUL_W-1:0] m3,
                                       input logic [MUL_W-1:0] m4);
      logic [MUL_W-1:0] rw;
      rw = MUL_W'(r);
      return 3'(rw >= MUL_W'(m1)) + 3'(rw >= m2) + 3'(rw >= m3) + 3'(rw >= m4);
   endfunction

   function automatic logic [DIGIT_W-1:0] ratio_digit(input logic [2:0] ql,
                                                      input logic [2:0] qz,
                                                      input logic [2:0] qf);
      logic [DIGIT_W-1:0] d;
      unique case ({ql, qz, qf})
         {3'd2, 3'd1, 3'd1}: d = 4'd0;
         {3'd2, 3'd2, 3'd1}: d = 4'd1;
         {3'd1, 3'd2, 3'd2}: d = 4'd2;
         {3'd4, 3'd1, 3'd1}: d = 4'd3;
         {3'd1, 3'd3, 3'd2}: d = 4'd4;
         {3'd2, 3'd3, 3'd1}: d = 4'd5;
         {3'd1, 3'd1, 3'd4}: d = 4'd6;
         {3'd3, 3'd1, 3'd2}: d = 4'd7;
         {3'd2, 3'd1, 3'd3}: d = 4'd8;
         {3'd1, 3'd1, 3'd2}: d = 4'd9;
         default:            d = DIGIT_BAD;
      endcase
      return d;
   endfunction

   // remainder by ten through the reciprocal 205 / 2048, exact for every 8-bit input
   function automatic logic [3:0] mod_ten(input logic [7:0] v);
      logic [15:0] p;
      logic [7:0]  q;
      p = 16'(v) * 16'd205;
      q = 8'(p[15:11]);
      return 4'(v - q * 8'd10);
   endfunction

   assign pop = (state_ff == ST_IDLE) && !fifo_empty;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digit_total = rsp_total_ff;
   assign rsp_chan.frame_done  = 1'b1;

   always_comb begin
      q_last  = quot(word_ff.run_last, mn_ff, m2_ff, m3_ff, m4_ff);
      q_zero  = quot(word_ff.run_zero, mn_ff, m2_ff, m3_ff, m4_ff);
      q_first = quot(word_ff.run_first, mn_ff, m2_ff, m3_ff, m4_ff);
      over    = (MUL_W'(word_ff.run_last) >= m5_ff) || (MUL_W'(word_ff.run_zero) >= m5_ff) ||
                (MUL_W'(word_ff.run_first) >= m5_ff) || (mn_ff == '0);
      even    = 6'(store_ff[0]) + 6'(store_ff[2]) + 6'(store_ff[4]) + 6'(store_ff[6]);
      odd     = 6'(store_ff[1]) + 6'(store_ff[3]) + 6'(store_ff[5]) + 6'(store_ff[7]);
      chk     = 8'(even) + 8'({even, 1'b0}) + 8'(odd);
      total_sum = {1'b0, total_ff} + (TOTAL_W + 1)'(sum_ff);
   end

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      mn_in        = mn_ff;
      m2_in        = m2_ff;
      m3_in        = m3_ff;
      m4_in        = m4_ff;
      m5_in        = m5_ff;
      digit_in     = digit_ff;
      store_in     = store_ff;
      pos_in       = pos_ff;
      skip_in      = skip_ff;
      total_in     = total_ff;
      sum_in       = sum_ff;
      sum_ok_in    = sum_ok_ff;
      rsp_total_in = rsp_total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               word_in = pop_word;
               if (pop_word.frame_start) begin
                  total_in = '0;
                  pos_in   = POS_W'(CODE_DIGITS - 1);
                  skip_in  = 1'b0;
               end
               if (pop_word.pattern && !(skip_ff && !pop_word.frame_start)) begin
                  state_in = ST_MIN;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_MIN: begin
            mn_in = word_ff.run_first;
            if (word_ff.run_last < mn_in) mn_in = word_ff.run_last;
            if (word_ff.run_zero < mn_in) mn_in = word_ff.run_zero;
            state_in = ST_MULT;
         end
         ST_MULT: begin
            m2_in    = MUL_W'({mn_ff, 1'b0});
            m3_in    = MUL_W'({mn_ff, 1'b0}) + MUL_W'(mn_ff);
            m4_in    = MUL_W'({mn_ff, 2'b00});
            m5_in    = MUL_W'({mn_ff, 2'b00}) + MUL_W'(mn_ff);
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            digit_in = over ? DIGIT_BAD : ratio_digit(q_last, q_zero, q_first);
            state_in = ST_STORE;
         end
         ST_STORE: begin
            if (digit_ff == DIGIT_BAD) begin
               total_in = '0;
               skip_in  = 1'b1;
               state_in = ST_TAIL;
            end else begin
               store_in[pos_ff] = digit_ff;
               if (pos_ff == '0) begin
                  state_in = ST_CHECK;
               end else begin
                  pos_in   = pos_ff - POS_W'(1);
                  state_in = ST_TAIL;
               end
            end
         end
         ST_CHECK: begin
            sum_in    = 7'(even) + 7'(odd);
            sum_ok_in = (mod_ten(chk) == 4'd0);
            pos_in    = POS_W'(CODE_DIGITS - 1);
            state_in  = ST_TOTAL;
         end
         ST_TOTAL: begin
            if (sum_ok_ff) begin
               total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
            end
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            if (word_ff.row_end) begin
               pos_in  = POS_W'(CODE_DIGITS - 1);
               skip_in = 1'b0;
            end
            state_in = word_ff.frame_end ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      mn_ff        <= mn_in;
      m2_ff        <= m2_in;
      m3_ff        <= m3_in;
      m4_ff        <= m4_in;
      m5_ff        <= m5_in;
      digit_ff     <= digit_in;
      store_ff     <= store_in;
      sum_ff       <= sum_in;
      sum_ok_ff    <= sum_ok_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_W'(CODE_DIGITS - 1);
         skip_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/barcode_scanline_decoder.sv */
// Barcode scan line decoder.
// req_chan takes one image bit per word, a row fed right to left, with the
// bit above it and the row_end, frame_start and frame_end marks. rsp_chan
// gives one word per frame_end bit: the saturating digit total of the frame
// and frame_done, which is always 1.
// The front end measures the one/zero/one runs and accepts a bit every cycle
// while its four-word event queue has room. Only bits that close a pattern
// or carry a mark enter the queue. The back end drains the queue one event
// at a time: a mark alone passes through the idle and tail states, a
// pattern adds the min, mult, quotient and store states, and the eighth
// digit of a code adds the checksum test and the total update; an event
// that carries frame_end also loads the result in the out state. The back
// end sequencer sets the sustained rate; a pattern needs at least four
// bits. Reset empties the queue, clears the total and the row state, and
// drops any pending result. When the receiver stalls, the result is held
// in the output register, the back end waits on its next result, and once
// the queue fills req_chan.ready falls.
module barcode_scanline_decoder (
   input  logic       clock,
   input  logic       reset,
   bsd_req_if.sink    req_chan,
   bsd_rsp_if.source  rsp_chan
);
   import bsd_pkg::*;

   event_type push_word, pop_word;
   logic      push, pop, fifo_full, fifo_empty;

   bsd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .push      (push),
      .push_word (push_word)
   );

   bsd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .pop_word  (pop_word),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   bsd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_word   (pop_word),
      .fifo_empty (fifo_empty),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

/* hdl/bsd_checker.sv */
module bsd_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bsd_pkg::TOTAL_W-1:0] rsp_digit_total,
   input logic                        rsp_frame_done
);
   import bsd_pkg::*;

   // a result word always marks a frame
   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_done)
      else $error("result word without frame_done");

   // a stalled result holds its total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digit_total))
      else $error("stalled result changed");

   // reset drops any pending result
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the event queue is empty after reset, so the next bit is taken
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

   // a result never rises unless reset was low at each past sample the property checks
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2) && !$past(reset, 3))
      else $error("result appeared too soon after reset");

endmodule

bind barcode_scanline_decoder bsd_checker u_bsd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_digit_total (rsp_chan.digit_total),
   .rsp_frame_done  (rsp_chan.frame_done)
);
